@@ src/assert_macros.svh @@
// Assertion helpers for the RTL. Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ src/psi_pkg.sv @@
package psi_pkg;

  // Field widths.
  localparam int CoordW = 32;
  localparam int NormW  = 16;
  localparam int ProdW  = NormW + CoordW;
  localparam int DistW  = 50;
  localparam int DenW   = DistW + 1;
  localparam int MagW   = DistW;
  localparam int FracW  = 16;
  localparam int QW     = 32;
  localparam int OffShift = 14;

  // Configuration port.
  localparam int AddrW = 4;
  localparam int DataW = 32;

  localparam logic signed [NormW-1:0] NormZReset = 16'sd16384;

  localparam logic [QW-1:0] TMax = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] TMin = 32'h8000_0000;

  typedef enum logic [1:0] {
    SIDE_FRONT = 2'd0,
    SIDE_BACK  = 2'd1,
    SIDE_ON    = 2'd2
  } side_e;

  typedef enum logic [1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_NORMAL_Z     = 2'd2,
    REG_PLANE_OFFSET = 2'd3
  } reg_idx_e;

  // Plane held in the configuration registers.
  typedef struct packed {
    logic signed [NormW-1:0]  nx;
    logic signed [NormW-1:0]  ny;
    logic signed [NormW-1:0]  nz;
    logic signed [CoordW-1:0] offset;
  } plane_t;

  // One stage of the divider pipeline.
  typedef struct packed {
    logic            valid;
    logic [MagW-1:0] md;
    logic [MagW-1:0] rem;
    logic [QW-1:0]   dvd;
    logic [QW-1:0]   quo;
    logic            ovf;
    logic            neg;
    logic            par;
    side_e           start_side;
    side_e           end_side;
  } div_t;

  function automatic side_e side_of(logic signed [DistW-1:0] f);
    side_e s;
    if (f > 0) begin
      s = SIDE_FRONT;
    end else if (f < 0) begin
      s = SIDE_BACK;
    end else begin
      s = SIDE_ON;
    end
    return s;
  endfunction

endpackage

@@ src/psi_regs.sv @@
module psi_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [psi_pkg::AddrW-1:0] paddr,
  input  logic [psi_pkg::DataW-1:0] pwdata,
  output logic [psi_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output psi_pkg::plane_t           plane_o
);
  import psi_pkg::*;

  plane_t   plane_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q.nx     <= '0;
      plane_q.ny     <= '0;
      plane_q.nz     <= NormZReset;
      plane_q.offset <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_NORMAL_X:     plane_q.nx     <= pwdata[NormW-1:0];
        REG_NORMAL_Y:     plane_q.ny     <= pwdata[NormW-1:0];
        REG_NORMAL_Z:     plane_q.nz     <= pwdata[NormW-1:0];
        REG_PLANE_OFFSET: plane_q.offset <= pwdata[CoordW-1:0];
        default:          plane_q        <= plane_q;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    case (idx)
      REG_NORMAL_X:     prdata = DataW'(unsigned'(plane_q.nx));
      REG_NORMAL_Y:     prdata = DataW'(unsigned'(plane_q.ny));
      REG_NORMAL_Z:     prdata = DataW'(unsigned'(plane_q.nz));
      REG_PLANE_OFFSET: prdata = DataW'(unsigned'(plane_q.offset));
      default:          prdata = '0;
    endcase
  end

  assign plane_o = plane_q;

endmodule

@@ src/psi_front.sv @@
module psi_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              in_valid_i,
  input  psi_pkg::plane_t                   plane_i,
  input  logic signed [psi_pkg::CoordW-1:0] start_x_i,
  input  logic signed [psi_pkg::CoordW-1:0] start_y_i,
  input  logic signed [psi_pkg::CoordW-1:0] start_z_i,
  input  logic signed [psi_pkg::CoordW-1:0] end_x_i,
  input  logic signed [psi_pkg::CoordW-1:0] end_y_i,
  input  logic signed [psi_pkg::CoordW-1:0] end_z_i,
  output psi_pkg::div_t                     div_o
);
  import psi_pkg::*;

  // Stage 1: products of normal and coordinates.
  logic                     v1_q;
  logic signed [ProdW-1:0]  psx_q, psy_q, psz_q, pex_q, pey_q, pez_q;
  logic signed [CoordW-1:0] off1_q;

  // Stage 2: signed distances of both endpoints.
  logic                    v2_q;
  logic signed [DistW-1:0] num2_q, fend2_q;

  // Stage 3: denominator, sides and numerator magnitude.
  logic                    v3_q;
  logic signed [DenW-1:0]  den3_q;
  logic [MagW-1:0]         mn3_q;
  logic                    num_neg3_q, num_zero3_q;
  side_e                   ss3_q, es3_q;
  logic signed [DenW-1:0]  den3_d;
  logic signed [DistW-1:0] num_neg_val;

  // Stage 4: denominator magnitude and result sign.
  logic            v4_q;
  logic [MagW-1:0] mn4_q, md4_q;
  logic            neg4_q, par4_q;
  side_e           ss4_q, es4_q;
  logic signed [DenW-1:0] den_neg_val;

  // Stage 5: range check and divider seed.
  div_t            div_q;
  logic            ovf5_d;

  assign den3_d      = DenW'(fend2_q) - DenW'(num2_q);
  assign num_neg_val = -num2_q;
  assign den_neg_val = -den3_q;
  assign ovf5_d      = {{FracW{1'b0}}, mn4_q} >= {md4_q, {FracW{1'b0}}};

  // Valid bits move with the data; the divider seed is loaded beside its valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      div_q <= '0;
    end else if (en_i) begin
      v1_q             <= in_valid_i;
      v2_q             <= v1_q;
      v3_q             <= v2_q;
      v4_q             <= v3_q;
      div_q.valid      <= v4_q;
      div_q.md         <= md4_q;
      div_q.rem        <= {{FracW{1'b0}}, mn4_q[MagW-1:FracW]};
      div_q.dvd        <= {mn4_q[FracW-1:0], {(QW-FracW){1'b0}}};
      div_q.quo        <= '0;
      div_q.ovf        <= ovf5_d;
      div_q.neg        <= neg4_q;
      div_q.par        <= par4_q;
      div_q.start_side <= ss4_q;
      div_q.end_side   <= es4_q;
    end
  end

  // Payload path.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      psx_q  <= plane_i.nx * start_x_i;
      psy_q  <= plane_i.ny * start_y_i;
      psz_q  <= plane_i.nz * start_z_i;
      pex_q  <= plane_i.nx * end_x_i;
      pey_q  <= plane_i.ny * end_y_i;
      pez_q  <= plane_i.nz * end_z_i;
      off1_q <= plane_i.offset;

      num2_q  <= DistW'(psx_q) + DistW'(psy_q) + DistW'(psz_q)
               + (DistW'(off1_q) <<< OffShift);
      fend2_q <= DistW'(pex_q) + DistW'(pey_q) + DistW'(pez_q)
               + (DistW'(off1_q) <<< OffShift);

      den3_q      <= den3_d;
      mn3_q       <= num2_q[DistW-1] ? MagW'(unsigned'(num_neg_val))
                                     : MagW'(unsigned'(num2_q));
      num_neg3_q  <= num2_q[DistW-1];
      num_zero3_q <= (num2_q == '0);
      ss3_q       <= side_of(num2_q);
      es3_q       <= side_of(fend2_q);

      mn4_q  <= mn3_q;
      md4_q  <= den3_q[DenW-1] ? MagW'(unsigned'(den_neg_val))
                               : MagW'(unsigned'(den3_q));
      neg4_q <= !num_zero3_q && (num_neg3_q == den3_q[DenW-1]);
      par4_q <= (den3_q == '0);
      ss4_q  <= ss3_q;
      es4_q  <= es3_q;
    end
  end

  assign div_o = div_q;

endmodule

@@ src/psi_div_step.sv @@
module psi_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  psi_pkg::div_t d_i,
  output psi_pkg::div_t d_o
);
  import psi_pkg::*;

  div_t            stage_q;
  logic [MagW:0]   trial;
  logic [MagW:0]   diff;
  logic            fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {d_i.rem, d_i.dvd[QW-1]};
  assign diff  = trial - {1'b0, d_i.md};
  assign fits  = trial >= {1'b0, d_i.md};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q.valid      <= d_i.valid;
      stage_q.md         <= d_i.md;
      stage_q.rem        <= fits ? diff[MagW-1:0] : trial[MagW-1:0];
      stage_q.dvd        <= {d_i.dvd[QW-2:0], 1'b0};
      stage_q.quo        <= {d_i.quo[QW-2:0], fits};
      stage_q.ovf        <= d_i.ovf;
      stage_q.neg        <= d_i.neg;
      stage_q.par        <= d_i.par;
      stage_q.start_side <= d_i.start_side;
      stage_q.end_side   <= d_i.end_side;
    end
  end

  assign d_o = stage_q;

endmodule

@@ src/psi_out.sv @@
`include "assert_macros.svh"

module psi_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psi_pkg::div_t                 div_i,
  output logic                          en_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [psi_pkg::QW-1:0] crossing_t_o,
  output logic                          is_parallel_o,
  output logic                          is_saturated_o,
  output logic [1:0]                    start_side_o,
  output logic [1:0]                    end_side_o
);
  import psi_pkg::*;

  typedef struct packed {
    logic [QW-1:0] t;
    logic          par;
    logic          sat;
    side_e         start_side;
    side_e         end_side;
  } res_t;

  res_t res_d, out_q, skid_q;
  logic out_valid_q, skid_full_q;
  logic take, incoming;

  // Sign, saturation and the parallel case.
  always_comb begin
    res_d.par        = div_i.par;
    res_d.start_side = div_i.start_side;
    res_d.end_side   = div_i.end_side;
    res_d.sat        = 1'b0;
    res_d.t          = div_i.quo;
    if (div_i.par) begin
      res_d.t = '0;
    end else if (div_i.ovf) begin
      res_d.sat = 1'b1;
      res_d.t   = div_i.neg ? TMin : TMax;
    end else if (div_i.neg) begin
      if (div_i.quo > TMin) begin
        res_d.sat = 1'b1;
        res_d.t   = TMin;
      end else begin
        res_d.t = -div_i.quo;
      end
    end else if (div_i.quo > TMax) begin
      res_d.sat = 1'b1;
      res_d.t   = TMax;
    end
  end

  assign en_o     = !skid_full_q;
  assign take     = out_valid_q && out_ready_i;
  assign incoming = en_o && div_i.valid;

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (take) begin
        skid_full_q <= 1'b0;
      end
    end else if (incoming) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_full_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (incoming) begin
      if (!out_valid_q || take) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign crossing_t_o   = signed'(out_q.t);
  assign is_parallel_o  = out_q.par;
  assign is_saturated_o = out_q.sat;
  assign start_side_o   = out_q.start_side;
  assign end_side_o     = out_q.end_side;

  `ASSERT_IMPLY(a_skid_behind_out, skid_full_q, out_valid_q, "skid filled with output empty")
  `ASSERT_IMPLY(a_parallel_zero, out_valid_q && out_q.par, (out_q.t == '0) && !out_q.sat,
    "parallel result carries nonzero t or saturation")
  `ASSERT_IMPLY(a_sat_clamped, out_valid_q && out_q.sat, (out_q.t == TMax) || (out_q.t == TMin),
    "saturated result not clamped to a range limit")

endmodule

@@ src/plane_segment_intersection_core.sv @@
// Channel  | Direction | Handshake                  | Payload
// input    | in        | in_valid_i / in_ready_o    | start_{x,y,z}_i, end_{x,y,z}_i
// output   | out       | out_valid_o / out_ready_i  | crossing_t_o, is_parallel_o,
//          |           |                            | is_saturated_o, start/end_side_o
// config   | in        | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One segment is accepted per cycle unless a full skid entry holds in_ready_o low.
// The path runs through five arithmetic stages, a 32-stage restoring divider and the output register.
// rst_ni clears all valid bits and loads the plane registers with their reset values.
// A stall on the output fills the skid entry, then freezes the whole pipeline in place.
// in_ready_o depends only on registered state.

module plane_segment_intersection_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psi_pkg::AddrW-1:0]         paddr,
  input  logic [psi_pkg::DataW-1:0]         pwdata,
  output logic [psi_pkg::DataW-1:0]         prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [psi_pkg::CoordW-1:0] start_x_i,
  input  logic signed [psi_pkg::CoordW-1:0] start_y_i,
  input  logic signed [psi_pkg::CoordW-1:0] start_z_i,
  input  logic signed [psi_pkg::CoordW-1:0] end_x_i,
  input  logic signed [psi_pkg::CoordW-1:0] end_y_i,
  input  logic signed [psi_pkg::CoordW-1:0] end_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [psi_pkg::QW-1:0]     crossing_t_o,
  output logic                              is_parallel_o,
  output logic                              is_saturated_o,
  output logic [1:0]                        start_side_o,
  output logic [1:0]                        end_side_o
);
  import psi_pkg::*;

  plane_t plane;
  logic   en;
  div_t   div_stage [QW+1];

  // Configuration registers.
  psi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .plane_o (plane)
  );

  assign in_ready_o = en;

  // Distances, denominator and divider seed.
  psi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .plane_i    (plane),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .start_z_i  (start_z_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .end_z_i    (end_z_i),
    .div_o      (div_stage[0])
  );

  // One quotient bit per stage.
  for (genvar k = 0; k < QW; k++) begin : g_div
    psi_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    (div_stage[k]),
      .d_o    (div_stage[k+1])
    );
  end

  // Sign, clamping and output buffering.
  psi_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .div_i          (div_stage[QW]),
    .en_o           (en),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .crossing_t_o   (crossing_t_o),
    .is_parallel_o  (is_parallel_o),
    .is_saturated_o (is_saturated_o),
    .start_side_o   (start_side_o),
    .end_side_o     (end_side_o)
  );

endmodule

@@ sim/plane_crossing_checker.sv @@
module plane_crossing_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration port, observed only.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [psi_pkg::AddrW-1:0]         paddr,
  input  logic [psi_pkg::DataW-1:0]         pwdata,
  // Segment request channel.
  input  logic                              seg_valid_i,
  input  logic                              seg_ready_i,
  input  logic signed [psi_pkg::CoordW-1:0] start_x_i,
  input  logic signed [psi_pkg::CoordW-1:0] start_y_i,
  input  logic signed [psi_pkg::CoordW-1:0] start_z_i,
  input  logic signed [psi_pkg::CoordW-1:0] end_x_i,
  input  logic signed [psi_pkg::CoordW-1:0] end_y_i,
  input  logic signed [psi_pkg::CoordW-1:0] end_z_i,
  // Crossing result channel.
  input  logic                              res_valid_i,
  input  logic                              res_ready_i,
  input  logic [psi_pkg::QW-1:0]            crossing_t_i,
  input  logic                              is_parallel_i,
  input  logic                              is_saturated_i,
  input  logic [1:0]                        start_side_i,
  input  logic [1:0]                        end_side_i,
  // Status handed to the testbench top.
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o,
  output int                                parallel_o,
  output int                                saturated_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import psi_pkg::*;

  typedef struct {
    logic [QW-1:0] t;
    logic          par;
    logic          sat;
    side_e         start_side;
    side_e         end_side;
  } crossing_t;

  plane_t    plane;
  crossing_t crossings_q[$];
  crossing_t want;
  int        mismatches;
  int        checked;
  int        parallel_seen;
  int        saturated_seen;

  function automatic side_e side_of_dist(input longint f);
    side_e s;
    if (f > 0) begin
      s = SIDE_FRONT;
    end else if (f < 0) begin
      s = SIDE_BACK;
    end else begin
      s = SIDE_ON;
    end
    return s;
  endfunction

  // Exact crossing parameter: all sums are formed in Q.30 without rounding, and the
  // only rounding is the scaled division, truncated toward zero.
  function automatic crossing_t predict_crossing(
    input plane_t                    pl,
    input logic signed [CoordW-1:0]  sx, sy, sz, ex, ey, ez
  );
    longint       nx, ny, nz, off;
    longint       num, far_dist, den;
    logic [127:0] mag_num, mag_den, quo;
    crossing_t    r;
    nx  = $signed(pl.nx);
    ny  = $signed(pl.ny);
    nz  = $signed(pl.nz);
    off = $signed(pl.offset);
    num      = nx * sx + ny * sy + nz * sz + off * 16384;
    far_dist = nx * ex + ny * ey + nz * ez + off * 16384;
    den      = nx * (ex - sx) + ny * (ey - sy) + nz * (ez - sz);
    r.start_side = side_of_dist(num);
    r.end_side   = side_of_dist(far_dist);
    r.t   = '0;
    r.par = 1'b0;
    r.sat = 1'b0;
    if (den == 0) begin
      r.par = 1'b1;
    end else begin
      mag_num = 128'((num < 0) ? -num : num);
      mag_den = 128'((den < 0) ? -den : den);
      quo     = (mag_num << 16) / mag_den;
      // t = -num / den is negative when num and den share a sign.
      if (num != 0 && ((num < 0) == (den < 0))) begin
        if (quo > 128'h8000_0000) begin
          r.sat = 1'b1;
          r.t   = TMin;
        end else begin
          r.t = ~quo[QW-1:0] + 32'd1;
        end
      end else if (quo > 128'h7FFF_FFFF) begin
        r.sat = 1'b1;
        r.t   = TMax;
      end else begin
        r.t = quo[QW-1:0];
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v, got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane.nx       = '0;
      plane.ny       = '0;
      plane.nz       = NormZReset;
      plane.offset   = '0;
      crossings_q.delete();
      mismatches     = 0;
      checked        = 0;
      parallel_seen  = 0;
      saturated_seen = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
      checked_o      <= 0;
      parallel_o     <= 0;
      saturated_o    <= 0;
    end else begin
      // Track the plane registers through completed writes.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_NORMAL_X:     plane.nx     = pwdata[NormW-1:0];
          REG_NORMAL_Y:     plane.ny     = pwdata[NormW-1:0];
          REG_NORMAL_Z:     plane.nz     = pwdata[NormW-1:0];
          REG_PLANE_OFFSET: plane.offset = pwdata[CoordW-1:0];
          default: ;
        endcase
      end

      // Compare each delivered result with the oldest outstanding request.
      if (res_valid_i && res_ready_i) begin
        if (crossings_q.size() == 0) begin
          mismatches++;
          $error("result delivered with no request outstanding");
        end else begin
          want = crossings_q.pop_front();
          check_field("crossing_t", want.t, crossing_t_i);
          check_field("is_parallel", 32'(want.par), 32'(is_parallel_i));
          check_field("is_saturated", 32'(want.sat), 32'(is_saturated_i));
          check_field("start_side", 32'(want.start_side), 32'(start_side_i));
          check_field("end_side", 32'(want.end_side), 32'(end_side_i));
          checked++;
          if (want.par) begin
            parallel_seen++;
          end
          if (want.sat) begin
            saturated_seen++;
          end
        end
      end

      // Predict the result of each accepted segment.
      if (seg_valid_i && seg_ready_i) begin
        crossings_q.push_back(predict_crossing(plane, start_x_i, start_y_i, start_z_i,
                                               end_x_i, end_y_i, end_z_i));
      end

      fail_count_o <= mismatches;
      pending_o    <= crossings_q.size();
      checked_o    <= checked;
      parallel_o   <= parallel_seen;
      saturated_o  <= saturated_seen;
    end
  end

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psi_pkg::*;

  localparam int unsigned      CycleLimit       = 1_000_000;
  localparam int               RandomPhases     = 8;
  localparam int               SegmentsPerPhase = 170;
  localparam logic signed [31:0] One      = 32'sh0001_0000;
  localparam logic signed [31:0] CoordMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CoordMin = 32'sh8000_0000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [CoordW-1:0] start_x  = '0;
  logic signed [CoordW-1:0] start_y  = '0;
  logic signed [CoordW-1:0] start_z  = '0;
  logic signed [CoordW-1:0] end_x    = '0;
  logic signed [CoordW-1:0] end_y    = '0;
  logic signed [CoordW-1:0] end_z    = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [QW-1:0] crossing_t;
  logic                 is_parallel;
  logic                 is_saturated;
  logic [1:0]           start_side;
  logic [1:0]           end_side;

  int fail_count;
  int pending;
  int checked;
  int parallel_seen;
  int saturated_seen;

  logic        steady_flow = 1'b0;
  int          stall_hold  = 0;
  int unsigned cycle_count = 0;
  int          planes_used = 1;

  always #6 clk = ~clk;

  plane_segment_intersection_core u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .start_x_i      (start_x),
    .start_y_i      (start_y),
    .start_z_i      (start_z),
    .end_x_i        (end_x),
    .end_y_i        (end_y),
    .end_z_i        (end_z),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .crossing_t_o   (crossing_t),
    .is_parallel_o  (is_parallel),
    .is_saturated_o (is_saturated),
    .start_side_o   (start_side),
    .end_side_o     (end_side)
  );

  plane_crossing_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .seg_valid_i    (in_valid),
    .seg_ready_i    (in_ready),
    .start_x_i      (start_x),
    .start_y_i      (start_y),
    .start_z_i      (start_z),
    .end_x_i        (end_x),
    .end_y_i        (end_y),
    .end_z_i        (end_z),
    .res_valid_i    (out_valid),
    .res_ready_i    (out_ready),
    .crossing_t_i   (crossing_t),
    .is_parallel_i  (is_parallel),
    .is_saturated_i (is_saturated),
    .start_side_i   (start_side),
    .end_side_i     (end_side),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .parallel_o     (parallel_seen),
    .saturated_o    (saturated_seen)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side backpressure: mostly short stalls, occasionally a long one; none while steady_flow is set.
  always @(posedge clk) begin
    if (steady_flow) begin
      out_ready  <= 1'b1;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          out_ready  <= 1'b1;
          stall_hold = $urandom_range(0, 8);
        end
        6, 7, 8: begin
          out_ready  <= 1'b0;
          stall_hold = $urandom_range(0, 3);
        end
        default: begin
          out_ready  <= 1'b0;
          stall_hold = $urandom_range(10, 60);
        end
      endcase
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 50);
  endfunction

  function automatic logic signed [31:0] small_coord();
    return int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
  endfunction

  // Present one segment request, hold it until accepted, then sometimes drop valid for a random gap.
  task automatic send_segment(input logic signed [31:0] sx, sy, sz, ex, ey, ez);
    int gap;
    in_valid <= 1'b1;
    start_x  <= sx;
    start_y  <= sy;
    start_z  <= sz;
    end_x    <= ex;
    end_y    <= ey;
    end_z    <= ez;
    do @(posedge clk); while (!in_ready);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Load a new plane; upper bits of the 16-bit registers carry junk on purpose.
  task automatic set_plane(input logic signed [15:0] nx, ny, nz,
                           input logic signed [31:0] offset);
    drain_requests();
    apb_write(REG_NORMAL_X, {16'($urandom), nx});
    apb_write(REG_NORMAL_Y, {16'($urandom), ny});
    apb_write(REG_NORMAL_Z, {16'($urandom), nz});
    apb_write(REG_PLANE_OFFSET, offset);
    planes_used++;
  endtask

  task automatic send_random_segment();
    logic signed [31:0] pt[6];
    int kind;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 6; i++) begin
      pt[i] = $urandom;
    end
    if (kind < 35) begin
      // Fully random endpoints.
    end else if (kind < 60) begin
      for (int i = 0; i < 6; i++) begin
        pt[i] = small_coord();
      end
    end else if (kind < 72) begin
      // Degenerate segment: no direction at all.
      for (int i = 0; i < 3; i++) begin
        pt[i + 3] = pt[i];
      end
    end else if (kind < 82) begin
      for (int i = 0; i < 6; i++) begin
        case ($urandom_range(0, 5))
          0: pt[i] = CoordMax;
          1: pt[i] = CoordMin;
          2: pt[i] = 0;
          3: pt[i] = 1;
          4: pt[i] = -1;
          default: ;
        endcase
      end
    end else if (kind < 92) begin
      // A step of a few LSBs drives the quotient out of range.
      if ($urandom_range(0, 1) == 1) begin
        for (int i = 0; i < 3; i++) begin
          pt[i] = small_coord();
        end
      end
      for (int i = 0; i < 3; i++) begin
        pt[i + 3] = pt[i] + int'($urandom_range(0, 4)) - 2;
      end
    end else begin
      // Mirrored endpoints straddle any plane through the origin.
      for (int i = 0; i < 3; i++) begin
        pt[i]     = small_coord();
        pt[i + 3] = -pt[i];
      end
    end
    send_segment(pt[0], pt[1], pt[2], pt[3], pt[4], pt[5]);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset plane is z = 0 with the normal along +z.
    send_segment(0, 0, One, 0, 0, -One);
    send_segment(One, -One, 5 * One, 3, 7, 5 * One);
    send_segment(7, 7, 0, 0, 0, One);
    send_segment(1, 2, 0, 3, 4, 0);
    send_segment(0, 0, -One, 0, 0, -2 * One);
    // Quotient at and just past the negative end of the Q16.16 range, just inside and just past the positive end.
    send_segment(0, 0, 32768, 0, 0, 32769);
    send_segment(0, 0, 32769, 0, 0, 32770);
    send_segment(0, 0, -32767, 0, 0, -32766);
    send_segment(0, 0, -32768, 0, 0, -32767);
    // Truncation toward zero on both signs.
    send_segment(0, 0, 1, 0, 0, 4);
    send_segment(0, 0, -1, 0, 0, 2);
    send_segment(CoordMin, CoordMax, CoordMax, CoordMax, CoordMin, CoordMin);
    send_segment(CoordMax, CoordMin, CoordMin, CoordMin, CoordMax, CoordMax);

    // Extreme plane registers.
    set_plane(16'sh7FFF, 16'sh8000, 16'sh8000, CoordMax);
    send_segment(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax);
    send_segment(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin);
    send_segment(CoordMax, CoordMin, CoordMin, CoordMin, CoordMax, CoordMax);
    send_segment(CoordMin, CoordMax, CoordMax, CoordMax, CoordMin, CoordMin);
    send_segment(0, 0, 0, 0, 0, 0);
    set_plane(16'sh8000, 16'sh7FFF, 16'sh0000, CoordMin);
    send_segment(0, 0, 0, 0, 0, 0);
    send_segment(CoordMin, CoordMax, 0, CoordMax, CoordMin, 5);
    send_segment(CoordMax, CoordMax, CoordMin, CoordMin, CoordMin, CoordMax);

    // Random traffic under a series of plane settings.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        1: set_plane(($urandom_range(0, 1) == 1) ? 16'sd16384 : -16'sd16384, 0, 0,
                     small_coord());
        2: set_plane(0, 0, 0, ($urandom_range(0, 2) == 0) ? 32'sd0 : 32'($urandom));
        3: set_plane(16'(int'($urandom_range(0, 32768)) - 16384),
                     16'(int'($urandom_range(0, 32768)) - 16384),
                     16'(int'($urandom_range(0, 32768)) - 16384), small_coord());
        5: set_plane(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, CoordMin);
        6: set_plane(0, -16'sd16384, 16'sd16384, 0);
        default: set_plane(16'($urandom), 16'($urandom), 16'($urandom), $urandom);
      endcase
      steady_flow <= (phase == 3 || phase == 6);
      for (int n = 0; n < SegmentsPerPhase; n++) begin
        send_random_segment();
        if ($urandom_range(0, 199) == 0) begin
          drain_requests();
        end
      end
    end

    drain_requests();
    repeat (48) @(posedge clk);

    $display("Checked %0d segment results across %0d plane settings.", checked, planes_used);
    $display("Parallel cases: %0d, saturated cases: %0d.", parallel_seen, saturated_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/psi_pkg.sv
src/psi_regs.sv
src/psi_front.sv
src/psi_div_step.sv
src/psi_out.sv
src/plane_segment_intersection_core.sv
sim/plane_crossing_checker.sv
sim/tb.sv
